@@ rtl/tcpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared sizes and codes of the two-class ticket priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  localparam int DEPTH       = 32;
  localparam int TICKET_BITS = 16;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int OCC_W       = $clog2(DEPTH + 1);
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int TIME_W      = 16;

  localparam logic [TIME_W-1:0] AGE_THRESHOLD_RST = TIME_W'(120);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ     = 3'd0,
    CMD_DEQ     = 3'd1,
    CMD_PROMOTE = 3'd2,
    CMD_REMOVE  = 3'd3,
    CMD_TIME    = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

`default_nettype wire

@@ rtl/two_class_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// two_class_priority_queue_top
// Ticket queue with urgent and normal classes, FIFO within each class.
//
//   channel   | signals                                        | handshake
//   ----------+------------------------------------------------+------------------
//   command   | command_i ticket_i urgent_in_i current_time_i  | start_i & !busy_o
//   result    | status_o ticket_out_o urgent_out_o occupancy_o | done_o, one cycle
//   config    | cfg_wdata_i (age threshold)                    | cfg_we_i
//
// Steps: a command beat is accepted, then its result beat is given; a search
// reads and compares one slot at a time, a shift reads and writes each entry
// that it moves, and an insert after a shift writes the hole, all through the
// single ticket RAM port pair and its registered read. The worst case is a
// promote of the tail entry with no urgent entries.
// Reset empties the queue and loads the threshold with 120; no clearing pass.
// The result beat cannot be stalled; busy_o falls right after done_o.
// Urgent entries always form a prefix, so the class of a slot is held only as
// the count of urgent entries.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_queue_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output      logic                              busy_o,
  input  wire logic [tcpq_pkg::CMD_W-1:0]        command_i,
  input  wire logic [tcpq_pkg::TICKET_BITS-1:0]  ticket_i,
  input  wire logic                              urgent_in_i,
  input  wire logic [tcpq_pkg::TIME_W-1:0]       current_time_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [tcpq_pkg::TIME_W-1:0]       cfg_wdata_i,
  output      logic                              done_o,
  output      logic [tcpq_pkg::STATUS_W-1:0]     status_o,
  output      logic [tcpq_pkg::TICKET_BITS-1:0]  ticket_out_o,
  output      logic                              urgent_out_o,
  output      logic [tcpq_pkg::OCC_W-1:0]        occupancy_o
);

  import tcpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_UP_RD,
    S_UP_WR,
    S_UP_INS,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } state_e;

  state_e                 state_q;
  cmd_e                   cmd_q;
  logic [TICKET_BITS-1:0] ticket_q;
  logic [PTR_W-1:0]       idx_q;
  logic [PTR_W-1:0]       pos_q;
  logic [OCC_W-1:0]       count_q;
  logic [OCC_W-1:0]       ucount_q;
  logic [TIME_W-1:0]      thr_q;
  status_e                status_q;
  logic [TICKET_BITS-1:0] tout_q;
  logic                   uout_q;

  // ticket RAM
  logic [TICKET_BITS-1:0] slot_ticket_q [DEPTH];
  logic [TICKET_BITS-1:0] rdata_q;
  logic                   mem_we;
  logic [PTR_W-1:0]       mem_waddr;
  logic [TICKET_BITS-1:0] mem_wdata;
  logic [PTR_W-1:0]       mem_raddr;

  logic             accept;
  logic [PTR_W-1:0] idx_inc;
  logic [PTR_W-1:0] idx_dec;
  logic [OCC_W-1:0] idx_ext;
  logic             hit;
  logic             last;
  logic             idx_urgent;
  logic             full;
  logic             tail_ins;

  assign accept     = start_i && (state_q == S_IDLE);
  assign idx_inc    = idx_q + PTR_W'(1);
  assign idx_dec    = idx_q - PTR_W'(1);
  assign idx_ext    = OCC_W'(idx_q);
  assign hit        = (cmd_q == CMD_DEQ) || (rdata_q == ticket_q);
  assign last       = (idx_ext + OCC_W'(1)) == count_q;
  assign idx_urgent = idx_ext < ucount_q;
  assign full       = count_q == OCC_W'(DEPTH);
  // an enqueue lands on the tail when it is normal or all entries are urgent
  assign tail_ins   = !urgent_in_i || (ucount_q == count_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rdata_q;
    mem_raddr = idx_q;
    case (state_q)
      S_IDLE: begin
        mem_waddr = count_q[PTR_W-1:0];
        mem_wdata = ticket_i;
        mem_we    = accept && (cmd_e'(command_i) == CMD_ENQ) && !full && tail_ins;
      end
      S_UP_RD: begin
        mem_raddr = idx_dec;
      end
      S_UP_WR: begin
        mem_we = 1'b1;
      end
      S_UP_INS: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = ticket_q;
      end
      S_DN_RD: begin
        mem_raddr = idx_inc;
      end
      S_DN_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_ticket_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= slot_ticket_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= AGE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= CMD_ENQ;
      ticket_q <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
      count_q  <= '0;
      ucount_q <= '0;
      status_q <= ST_OK;
      tout_q   <= '0;
      uout_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= cmd_e'(command_i);
            ticket_q <= ticket_i;
            tout_q   <= '0;
            uout_q   <= 1'b0;
            case (cmd_e'(command_i))
              CMD_ENQ: begin
                if (full) begin
                  status_q <= ST_FULL;
                  state_q  <= S_DONE;
                end else if (tail_ins) begin
                  status_q <= ST_OK;
                  state_q  <= S_DONE;
                  count_q  <= count_q + OCC_W'(1);
                  if (urgent_in_i) begin
                    ucount_q <= ucount_q + OCC_W'(1);
                  end
                end else begin
                  // open a hole at the end of the urgent section
                  status_q <= ST_OK;
                  idx_q    <= count_q[PTR_W-1:0];
                  pos_q    <= ucount_q[PTR_W-1:0];
                  state_q  <= S_UP_RD;
                end
              end
              CMD_DEQ, CMD_PROMOTE, CMD_REMOVE: begin
                idx_q <= '0;
                if (count_q == '0) begin
                  status_q <= (cmd_e'(command_i) == CMD_DEQ) ? ST_EMPTY : ST_NOT_FOUND;
                  state_q  <= S_DONE;
                end else begin
                  status_q <= ST_OK;
                  state_q  <= S_SRCH_RD;
                end
              end
              CMD_TIME: begin
                status_q <= ST_OK;
                state_q  <= S_DONE;
                if (current_time_i > thr_q) begin
                  ucount_q <= count_q;
                end
              end
              default: begin
                status_q <= ST_OK;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH_RD: begin
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (hit) begin
            if (cmd_q == CMD_PROMOTE) begin
              if (idx_urgent) begin
                state_q <= S_DONE;
              end else if (idx_ext == ucount_q) begin
                ucount_q <= ucount_q + OCC_W'(1);
                state_q  <= S_DONE;
              end else begin
                pos_q   <= ucount_q[PTR_W-1:0];
                state_q <= S_UP_RD;
              end
            end else begin
              tout_q <= rdata_q;
              uout_q <= idx_urgent;
              if (last) begin
                count_q <= count_q - OCC_W'(1);
                if (idx_urgent) begin
                  ucount_q <= ucount_q - OCC_W'(1);
                end
                state_q <= S_DONE;
              end else begin
                state_q <= S_DN_RD;
              end
            end
          end else if (last) begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_DONE;
          end else begin
            idx_q   <= idx_inc;
            state_q <= S_SRCH_RD;
          end
        end
        S_UP_RD: begin
          state_q <= S_UP_WR;
        end
        S_UP_WR: begin
          idx_q   <= idx_dec;
          state_q <= (idx_dec == pos_q) ? S_UP_INS : S_UP_RD;
        end
        S_UP_INS: begin
          if (cmd_q == CMD_ENQ) begin
            count_q <= count_q + OCC_W'(1);
          end
          ucount_q <= ucount_q + OCC_W'(1);
          state_q  <= S_DONE;
        end
        S_DN_RD: begin
          state_q <= S_DN_WR;
        end
        S_DN_WR: begin
          if ((idx_ext + OCC_W'(2)) == count_q) begin
            count_q <= count_q - OCC_W'(1);
            if (uout_q) begin
              ucount_q <= ucount_q - OCC_W'(1);
            end
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_inc;
            state_q <= S_DN_RD;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = state_q != S_IDLE;
  assign done_o       = state_q == S_DONE;
  assign status_o     = status_q;
  assign ticket_out_o = tout_q;
  assign urgent_out_o = uout_q;
  assign occupancy_o  = count_q;

`ifndef SYNTHESIS
  a_ucount_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucount_q <= count_q)
    else $error("urgent count exceeds occupancy");

  a_count_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OCC_W'(DEPTH))
    else $error("occupancy exceeds depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted beat did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_q == ST_FULL)) |-> (count_q == OCC_W'(DEPTH)))
    else $error("full status with free slots");
`endif

endmodule

`default_nettype wire

@@ verif/two_class_priority_queue_top_test.sv @@
// ----------------------------------------------------------------------------
// two_class_priority_queue_top_test
// Self-checking bench for the two-class ticket queue. A scoreboard keeps its
// own copy of the queue, predicts every result beat from the accepted command
// beats and compares status, ticket, class and occupancy. Directed commands
// hit the corner cases, then random fill/drain traffic runs under several age
// thresholds, with random command gaps under all but one of them.
// ----------------------------------------------------------------------------
module two_class_priority_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpq_pkg::*;

  typedef struct packed {
    status_e                status;
    logic [TICKET_BITS-1:0] ticket;
    logic                   urgent;
    logic [OCC_W-1:0]       occupancy;
  } queue_result_t;

  class ticket_queue_scoreboard;
    logic [TIME_W-1:0]      threshold;
    logic [TICKET_BITS-1:0] held_ticket[$];
    bit                     held_urgent[$];
    queue_result_t          expected_results[$];
    int                     errors;
    int                     checked;
    int                     status_seen[4];

    function new();
      threshold = AGE_THRESHOLD_RST;
      errors    = 0;
      checked   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int find_ticket(logic [TICKET_BITS-1:0] t);
      foreach (held_ticket[i]) if (held_ticket[i] == t) return i;
      return -1;
    endfunction

    function int urgent_count();
      int n;
      n = 0;
      while (n < held_urgent.size() && held_urgent[n]) n++;
      return n;
    endfunction

    // Stimulus helper: mostly a ticket that is queued, so searches hit.
    function logic [TICKET_BITS-1:0] pick_ticket();
      if (held_ticket.size() != 0 && $urandom_range(99) < 75)
        return held_ticket[$urandom_range(held_ticket.size() - 1)];
      if ($urandom_range(1))
        return TICKET_BITS'($urandom_range(15));
      return TICKET_BITS'($urandom);
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [TICKET_BITS-1:0] t,
                               logic urg, logic [TIME_W-1:0] now);
      queue_result_t r;
      int            pos;
      r.status = ST_OK;
      r.ticket = '0;
      r.urgent = 1'b0;
      case (cmd)
        CMD_ENQ: begin
          if (held_ticket.size() >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = urg ? urgent_count() : held_ticket.size();
            held_ticket.insert(pos, t);
            held_urgent.insert(pos, urg);
          end
        end
        CMD_DEQ: begin
          if (held_ticket.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.ticket = held_ticket.pop_front();
            r.urgent = held_urgent.pop_front();
          end
        end
        CMD_PROMOTE: begin
          pos = find_ticket(t);
          if (pos < 0) begin
            r.status = ST_NOT_FOUND;
          end else if (!held_urgent[pos]) begin
            // urgent entries form a prefix: a normal entry moves to its end
            held_ticket.delete(pos);
            held_urgent.delete(pos);
            held_ticket.insert(urgent_count(), t);
            held_urgent.insert(urgent_count(), 1'b1);
          end
        end
        CMD_REMOVE: begin
          pos = find_ticket(t);
          if (pos < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.ticket = held_ticket[pos];
            r.urgent = held_urgent[pos];
            held_ticket.delete(pos);
            held_urgent.delete(pos);
          end
        end
        CMD_TIME: begin
          if (now > threshold)
            foreach (held_urgent[i]) held_urgent[i] = 1'b1;
        end
        default: ;
      endcase
      r.occupancy = OCC_W'(held_ticket.size());
      expected_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [TICKET_BITS-1:0] t,
                               logic urg, logic [OCC_W-1:0] occ);
      queue_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected, status %0d ticket 0x%0h",
                 $time, st, t);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(st));
      compare_field("ticket_out", 32'(want.ticket), 32'(t));
      compare_field("urgent_out", 32'(want.urgent), 32'(urg));
      compare_field("occupancy", 32'(want.occupancy), 32'(occ));
      status_seen[want.status]++;
      checked++;
    endfunction
  endclass

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start_i        = 1'b0;
  logic [CMD_W-1:0]       command_i      = '0;
  logic [TICKET_BITS-1:0] ticket_i       = '0;
  logic                   urgent_in_i    = 1'b0;
  logic [TIME_W-1:0]      current_time_i = '0;
  logic                   cfg_we_i       = 1'b0;
  logic [TIME_W-1:0]      cfg_wdata_i    = '0;
  logic                   busy_o;
  logic                   done_o;
  logic [STATUS_W-1:0]    status_o;
  logic [TICKET_BITS-1:0] ticket_out_o;
  logic                   urgent_out_o;
  logic [OCC_W-1:0]       occupancy_o;

  ticket_queue_scoreboard sb = new();
  bit                     gaps_on = 1'b1;
  int                     settings_used = 1;

  two_class_priority_queue_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .ticket_i       (ticket_i),
    .urgent_in_i    (urgent_in_i),
    .current_time_i (current_time_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .ticket_out_o   (ticket_out_o),
    .urgent_out_o   (urgent_out_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Values seen here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(status_o, ticket_out_o, urgent_out_o, occupancy_o);
      if (start_i && !busy_o) sb.note_command(command_i, ticket_i, urgent_in_i, current_time_i);
    end
  end

  // Returns at the edge that accepts the beat; start stays high for a following beat.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [TICKET_BITS-1:0] t,
                              logic urg, logic [TIME_W-1:0] now);
    if (gaps_on && $urandom_range(99) < 32) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    command_i      <= cmd;
    ticket_i       <= t;
    urgent_in_i    <= urg;
    current_time_i <= now;
    do @(posedge clk_i); while (busy_o);
  endtask

  // One edge first, so a beat accepted at the current edge is already busy.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [TIME_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.threshold = value;
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // fill: enqueue-heavy so the queue reaches full; otherwise drain.
  task automatic random_command(bit fill);
    int                     pick;
    logic [CMD_W-1:0]       cmd;
    logic [TICKET_BITS-1:0] t;
    logic [TIME_W-1:0]      now;
    pick = $urandom_range(99);
    if (fill)
      cmd = pick < 75 ? CMD_ENQ : pick < 80 ? CMD_DEQ : pick < 88 ? CMD_PROMOTE :
            pick < 93 ? CMD_REMOVE : pick < 98 ? CMD_TIME : CMD_W'($urandom_range(5, 7));
    else
      cmd = pick < 25 ? CMD_ENQ : pick < 65 ? CMD_DEQ : pick < 75 ? CMD_PROMOTE :
            pick < 92 ? CMD_REMOVE : pick < 98 ? CMD_TIME : CMD_W'($urandom_range(5, 7));
    if (cmd == CMD_PROMOTE || cmd == CMD_REMOVE)
      t = sb.pick_ticket();
    else if ($urandom_range(99) < 70)
      t = TICKET_BITS'($urandom_range(15));
    else
      t = TICKET_BITS'($urandom);
    case ($urandom_range(3))
      0: now = sb.threshold;
      1: now = sb.threshold + 1'b1;
      2: now = sb.threshold - 1'b1;
      default: now = TIME_W'($urandom);
    endcase
    send_command(cmd, t, $urandom_range(99) < 35, now);
  endtask

  initial begin
    logic [TIME_W-1:0] thresholds[5];
    thresholds[0] = '0;
    thresholds[1] = '1;
    thresholds[2] = TIME_W'($urandom);
    thresholds[3] = TIME_W'(1);
    thresholds[4] = AGE_THRESHOLD_RST;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases on an empty queue
    send_command(CMD_DEQ, '0, 1'b0, '0);
    send_command(CMD_PROMOTE, 16'h0005, 1'b1, '0);
    send_command(CMD_REMOVE, 16'h0005, 1'b0, '0);
    send_command(CMD_TIME, '1, 1'b1, '0);
    // build a mixed queue, duplicates included
    send_command(CMD_ENQ, 16'hFFFF, 1'b0, '1);
    send_command(CMD_ENQ, 16'h0000, 1'b0, '0);
    send_command(CMD_ENQ, 16'h1234, 1'b1, '0);
    send_command(CMD_ENQ, 16'h00AA, 1'b0, '0);
    send_command(CMD_ENQ, 16'h5555, 1'b1, '0);
    send_command(CMD_ENQ, 16'h00AA, 1'b1, '0);
    send_command(CMD_PROMOTE, 16'h0000, 1'b0, '0);
    send_command(CMD_PROMOTE, 16'h1234, 1'b0, '0);
    send_command(CMD_PROMOTE, 16'h7777, 1'b0, '0);
    // first match is the urgent copy, the second remove hits the tail
    send_command(CMD_REMOVE, 16'h00AA, 1'b0, '0);
    send_command(CMD_REMOVE, 16'h00AA, 1'b0, '0);
    send_command(CMD_ENQ, 16'h0F0F, 1'b0, '0);
    send_command(CMD_TIME, '0, 1'b0, AGE_THRESHOLD_RST);
    send_command(CMD_TIME, '0, 1'b0, AGE_THRESHOLD_RST + 1'b1);
    send_command(CMD_W'(5), 16'hA5A5, 1'b1, '1);
    send_command(CMD_W'(6), 16'h5A5A, 1'b0, '0);
    send_command(CMD_W'(7), 16'hFFFF, 1'b1, '1);
    send_command(CMD_DEQ, '1, 1'b1, '1);
    send_command(CMD_DEQ, '0, 1'b0, '0);
    send_command(CMD_TIME, '0, 1'b0, '1);

    foreach (thresholds[p]) begin
      drain_results();
      write_threshold(thresholds[p]);
      gaps_on = (p != 2);
      for (int i = 0; i < 80; i++) random_command(i < 50);
    end

    drain_results();
    repeat (4 * DEPTH + 4) @(posedge clk_i);
    $display("Checked %0d result beats under %0d threshold settings (0 and max included)",
             sb.checked, settings_used);
    $display("Status mix: ok %0d, empty %0d, not found %0d, full %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL]);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Run did not finish in time, %0d beats still expected",
             sb.expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
